FILE: rtl/slt_pkg.sv
`default_nettype none

package slt_pkg;

  // Field widths fixed by the command and result formats
  localparam int VALUE_W          = 32;
  localparam int POS_W            = 4;
  localparam int ACT_W            = 2;
  localparam int ST_W             = 3;
  localparam int IN_TDATA_W       = ((VALUE_W + POS_W + 7) / 8) * 8;
  localparam int DEFAULT_CAPACITY = 8;

  // Command codes
  localparam logic [ACT_W-1:0] ACT_INSERT   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SEARCH   = 2'd2;
  localparam logic [ACT_W-1:0] ACT_RETRIEVE = 2'd3;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
  localparam logic [ST_W-1:0] ST_BADPOS   = 3'd2;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

  // Broadcast from the control to every cell of the row
  typedef struct packed {
    logic                      do_ins;
    logic                      do_rem;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          pos;
  } cell_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/sorted_list_table_unit.sv
`default_nettype none

// Sorted list table: keeps up to CAPACITY signed 32-bit values in ascending
// order in a row of cells, one entry per cell. Each input item is a command
// (in_tuser): insert a value after any equal entries, remove the entry at a
// position, search for the lowest index holding a value, or retrieve the
// entry at a position. Every command yields exactly one result item with a
// status (out_tuser) and the entry count after the command. All cells compare
// against the broadcast value and shift toward their neighbor in the same
// cycle, so the result appears on the output register the cycle after
// acceptance, and a new command is accepted every cycle while the output side
// keeps taking results. After reset the list is empty and commands are
// accepted at once.
module sorted_list_table_unit import slt_pkg::*; #(
  parameter int  CAPACITY    = DEFAULT_CAPACITY,
  localparam int IDX_W       = $clog2(CAPACITY),
  localparam int CNT_W       = $clog2(CAPACITY + 1),
  localparam int OUT_TDATA_W = ((IDX_W + VALUE_W + CNT_W + 7) / 8) * 8
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_tvalid,
  output logic                   in_tready,
  // value [31:0], position [35:32], zero fill above
  input  wire [IN_TDATA_W-1:0]   in_tdata,
  // action
  input  wire [ACT_W-1:0]        in_tuser,
  output logic                   out_tvalid,
  input  wire                    out_tready,
  // found_index, read_value, entry_total from bit 0 up, zero fill above
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // status
  output logic [ST_W-1:0]        out_tuser
);

  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W + 1 : POS_W + 1;

  logic                      accept;
  logic [ACT_W-1:0]          action;
  logic signed [VALUE_W-1:0] value;
  logic [POS_W-1:0]          pos;
  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          count_nxt;
  logic                      full;
  logic                      empty;
  logic                      pos_ok;
  cell_cmd_t                 cmd;

  logic signed [VALUE_W-1:0] ent [CAPACITY];
  logic                      gt  [CAPACITY];
  logic                      eq  [CAPACITY];

  logic                      hit;
  logic [IDX_W-1:0]          hit_idx;
  logic signed [VALUE_W-1:0] pick;

  logic                      out_valid_r;
  logic [ST_W-1:0]           status_r;
  logic [ST_W-1:0]           status_nxt;
  logic [IDX_W-1:0]          found_r;
  logic [IDX_W-1:0]          found_nxt;
  logic signed [VALUE_W-1:0] read_r;
  logic signed [VALUE_W-1:0] read_nxt;
  logic [CNT_W-1:0]          total_r;

  // Unpack the command
  assign action    = in_tuser;
  assign value     = in_tdata[VALUE_W-1:0];
  assign pos       = in_tdata[VALUE_W+POS_W-1:VALUE_W];
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign full   = count_r == CNT_W'(CAPACITY);
  assign empty  = count_r == '0;
  assign pos_ok = CMP_W'(pos) < CMP_W'(count_r);

  // Broadcast to the row
  always_comb begin
    cmd.do_ins = accept && (action == ACT_INSERT) && !full;
    cmd.do_rem = accept && (action == ACT_REMOVE) && pos_ok;
    cmd.value  = value;
    cmd.pos    = pos;
  end

  // Row of cells, each linked to its neighbors; the end cells tie off the missing side
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_W-1:0] left_entry;
    logic                      left_gt;
    logic signed [VALUE_W-1:0] right_entry;

    if (i == 0) begin : g_first
      assign left_entry = '0;
      assign left_gt    = 1'b0;
    end else begin : g_mid
      assign left_entry = ent[i-1];
      assign left_gt    = gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = ent[i];
    end else begin : g_inner
      assign right_entry = ent[i+1];
    end

    slt_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (i)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .count       (count_r),
      .left_entry  (left_entry),
      .left_gt     (left_gt),
      .right_entry (right_entry),
      .entry       (ent[i]),
      .gt          (gt[i]),
      .eq          (eq[i])
    );
  end

  // Pick the lowest matching cell and the entry at the position
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    pick    = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (eq[i]) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (CMP_W'(i) == CMP_W'(pos)) begin
        pick = ent[i];
      end
    end
  end

  // Form the result
  always_comb begin
    status_nxt = ST_OK;
    found_nxt  = '0;
    read_nxt   = '0;
    count_nxt  = count_r;
    unique case (action)
      ACT_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      ACT_REMOVE: begin
        if (!pos_ok) begin
          status_nxt = ST_BADPOS;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      ACT_SEARCH: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (!hit) begin
          status_nxt = ST_NOTFOUND;
        end else begin
          found_nxt = hit_idx;
        end
      end
      ACT_RETRIEVE: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (!pos_ok) begin
          status_nxt = ST_BADPOS;
        end else begin
          read_nxt = pick;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // Advance the count and hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      found_r  <= found_nxt;
      read_r   <= read_nxt;
      total_r  <= count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = OUT_TDATA_W'({total_r, read_r, found_r});

endmodule

`default_nettype wire

FILE: rtl/slt_cell.sv
`default_nettype none

module slt_cell import slt_pkg::*; #(
  parameter int  CAPACITY = DEFAULT_CAPACITY,
  parameter int  IDX      = 0,
  localparam int CNT_W    = $clog2(CAPACITY + 1),
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W + 1 : POS_W + 1
) (
  input  wire                       clk,
  input  wire cell_cmd_t            cmd,
  input  wire [CNT_W-1:0]           count,
  input  wire signed [VALUE_W-1:0]  left_entry,
  input  wire                       left_gt,
  input  wire signed [VALUE_W-1:0]  right_entry,
  output logic signed [VALUE_W-1:0] entry,
  output logic                      gt,
  output logic                      eq
);

  logic signed [VALUE_W-1:0] entry_r;
  logic signed [VALUE_W-1:0] entry_nxt;
  logic                      occupied;
  logic                      in_reach;
  logic                      at_or_after_pos;

  // Compare the broadcast value against the held entry
  assign occupied        = CNT_W'(IDX) < count;
  assign in_reach        = CNT_W'(IDX) <= count;
  assign at_or_after_pos = CMP_W'(cmd.pos) <= CMP_W'(IDX);
  assign gt              = occupied && (cmd.value < entry_r);
  assign eq              = occupied && (cmd.value == entry_r);
  assign entry           = entry_r;

  // Shift up on insert, shift down on remove, otherwise hold
  always_comb begin
    entry_nxt = entry_r;
    if (cmd.do_ins && in_reach) begin
      if (left_gt) begin
        entry_nxt = left_entry;
      end else if (!occupied || gt) begin
        entry_nxt = cmd.value;
      end
    end else if (cmd.do_rem && at_or_after_pos) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

FILE: tb/tb_sorted_list_table_unit.sv
`timescale 1ns / 100ps

module tb_sorted_list_table_unit;
  import slt_pkg::*;

  localparam int CAP        = DEFAULT_CAPACITY;
  localparam int RAND_CMDS  = 1630;
  localparam int STALL_LIM  = 5000;
  localparam int HOLD_LEN   = 250;
  localparam int HOLD_AT    = 400;
  localparam int QUIET_LO   = 1000;
  localparam int QUIET_HI   = 1400;

  typedef struct {
    logic [ACT_W-1:0]          act;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          pos;
  } list_cmd_t;

  typedef struct {
    logic [ST_W-1:0]           status;
    logic [2:0]                found;
    logic signed [VALUE_W-1:0] readv;
    logic [3:0]                total;
  } list_resp_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;   // value, position, zero fill
  logic [ACT_W-1:0]      in_tuser;   // action
  logic                  out_tvalid;
  logic                  out_tready;
  logic [39:0]           out_tdata;  // found_index, read_value, entry_total, zero fill
  logic [ST_W-1:0]       out_tuser;  // status

  list_cmd_t  cmd_q[$];
  list_resp_t resp_q[$];

  // Shadow of the table contents
  logic signed [VALUE_W-1:0] shadow_vals[CAP];
  int                        shadow_len;

  int   err_cnt;
  int   resp_seen;
  int   cyc;
  int   stall_cyc;
  logic cmd_fire;
  int   hold_left;
  logic hold_done;

  sorted_list_table_unit #(.CAPACITY(CAP)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic signed [VALUE_W-1:0] pick_value();
    logic signed [VALUE_W-1:0] v;
    case ($urandom_range(9))
      0:         v = 32'sh8000_0000;
      1:         v = 32'sh7fff_ffff;
      2, 3, 4,
      5, 6:      v = $urandom_range(6) - 3;
      default:   v = $urandom;
    endcase
    return v;
  endfunction

  // Apply one command to the shadow table and return its result
  function automatic list_resp_t table_apply(list_cmd_t c);
    list_resp_t r;
    int         i;
    r.status = ST_OK;
    r.found  = '0;
    r.readv  = '0;
    case (c.act)
      ACT_INSERT: begin
        if (shadow_len >= CAP) begin
          r.status = ST_FULL;
        end else begin
          i = shadow_len;
          while (i > 0 && c.value < shadow_vals[i-1]) begin
            shadow_vals[i] = shadow_vals[i-1];
            i--;
          end
          shadow_vals[i] = c.value;
          shadow_len++;
        end
      end
      ACT_REMOVE: begin
        if (int'(c.pos) >= shadow_len) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = int'(c.pos); i + 1 < shadow_len; i++)
            shadow_vals[i] = shadow_vals[i+1];
          shadow_len--;
        end
      end
      ACT_SEARCH: begin
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_NOTFOUND;
          for (i = 0; i < shadow_len; i++) begin
            if (shadow_vals[i] == c.value) begin
              r.status = ST_OK;
              r.found  = 3'(i);
              break;
            end
          end
        end
      end
      default: begin
        if (shadow_len == 0)
          r.status = ST_EMPTY;
        else if (int'(c.pos) >= shadow_len)
          r.status = ST_BADPOS;
        else
          r.readv = shadow_vals[c.pos[2:0]];
      end
    endcase
    r.total = 4'(shadow_len);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    err_cnt++;
  endtask

  task automatic push_cmd(logic [ACT_W-1:0] a, logic signed [VALUE_W-1:0] v,
                          logic [POS_W-1:0] p);
    list_cmd_t c;
    c.act   = a;
    c.value = v;
    c.pos   = p;
    cmd_q.push_back(c);
  endtask

  // Drive commands from the pending queue; hold an item until it is taken
  always @(negedge clk) begin
    list_cmd_t c;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || cmd_fire) begin
      if (cmd_q.size() != 0 &&
          !(!(cyc >= QUIET_LO && cyc < QUIET_HI) && $urandom_range(99) < 11)) begin
        c = cmd_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {{(IN_TDATA_W - VALUE_W - POS_W){1'b0}}, c.pos, c.value};
        in_tuser  <= c.act;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result side: random stalls plus one long hold-off to back up the block; always ready in the quiet window
  always @(negedge clk) begin
    if (!hold_done && resp_seen >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (cyc >= QUIET_LO && cyc < QUIET_HI) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 11);
    end
  end

  // Predict on each accepted command, check each accepted result
  always @(posedge clk) begin
    list_cmd_t  c;
    list_resp_t want;
    cyc++;
    cmd_fire <= in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        resp_seen++;
        if (resp_q.size() == 0) begin
          $display("[%0t] result with no command outstanding", $realtime);
          err_cnt++;
        end else begin
          want = resp_q.pop_front();
          if (out_tuser !== want.status)
            report_mismatch("status", out_tuser, want.status);
          if (out_tdata[2:0] !== want.found)
            report_mismatch("found_index", out_tdata[2:0], want.found);
          if (out_tdata[34:3] !== want.readv)
            report_mismatch("read_value", out_tdata[34:3], want.readv);
          if (out_tdata[38:35] !== want.total)
            report_mismatch("entry_total", out_tdata[38:35], want.total);
        end
      end
      if (in_tvalid && in_tready) begin
        c.act   = in_tuser;
        c.value = in_tdata[31:0];
        c.pos   = in_tdata[35:32];
        resp_q.push_back(table_apply(c));
      end
      // Watchdog: abort when nothing moves for too long
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        stall_cyc = 0;
      else
        stall_cyc++;
      if (stall_cyc >= STALL_LIM) begin
        $display("** sorted_list_table_unit: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int k;
    int bias;
    int r;
    err_cnt    = 0;
    resp_seen  = 0;
    cyc        = 0;
    stall_cyc  = 0;
    cmd_fire   = 1'b0;
    hold_left  = 0;
    hold_done  = 1'b0;
    shadow_len = 0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = ACT_INSERT;
    out_tready = 1'b0;

    // Directed: empty-list cases, extremes, duplicates, full, bad positions
    push_cmd(ACT_SEARCH,   32'sd5, 4'd0);
    push_cmd(ACT_RETRIEVE, 32'sd0, 4'd15);
    push_cmd(ACT_REMOVE,   32'sd0, 4'd0);
    push_cmd(ACT_INSERT,   32'sh7fff_ffff, 4'd0);
    push_cmd(ACT_INSERT,   32'sh8000_0000, 4'd0);
    push_cmd(ACT_INSERT,   32'sd0, 4'd0);
    push_cmd(ACT_INSERT,   -32'sd1, 4'd0);
    push_cmd(ACT_INSERT,   32'sd7, 4'd0);
    push_cmd(ACT_INSERT,   32'sd7, 4'd0);
    push_cmd(ACT_INSERT,   -32'sd1, 4'd0);
    push_cmd(ACT_INSERT,   32'sd7, 4'd0);
    push_cmd(ACT_INSERT,   32'sd3, 4'd0);
    push_cmd(ACT_SEARCH,   32'sd7, 4'd0);
    push_cmd(ACT_SEARCH,   32'sh8000_0000, 4'd0);
    push_cmd(ACT_SEARCH,   32'sh7fff_ffff, 4'd0);
    push_cmd(ACT_SEARCH,   32'sd1234, 4'd0);
    push_cmd(ACT_RETRIEVE, 32'sd0, 4'd0);
    push_cmd(ACT_RETRIEVE, 32'sd0, 4'd7);
    push_cmd(ACT_RETRIEVE, 32'sd0, 4'd8);
    push_cmd(ACT_REMOVE,   32'sd0, 4'd15);
    push_cmd(ACT_REMOVE,   32'sd0, 4'd7);
    push_cmd(ACT_REMOVE,   32'sd0, 4'd0);
    push_cmd(ACT_RETRIEVE, 32'sd0, 4'd6);
    push_cmd(ACT_REMOVE,   32'sd0, 4'd3);

    // Random: phases leaning toward filling, draining or mixed traffic
    bias = 0;
    for (k = 0; k < RAND_CMDS; k++) begin
      if (k % 40 == 0)
        bias = $urandom_range(2);
      r = $urandom_range(99);
      if (bias == 0 && r < 55 || bias == 1 && r < 15 || bias == 2 && r < 30)
        push_cmd(ACT_INSERT, pick_value(), 4'($urandom_range(15)));
      else if (bias == 0 && r < 70 || bias == 1 && r < 65 || bias == 2 && r < 50)
        push_cmd(ACT_REMOVE, pick_value(),
                 4'(($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(7)));
      else if (r < 85)
        push_cmd(ACT_SEARCH, pick_value(), 4'($urandom_range(15)));
      else
        push_cmd(ACT_RETRIEVE, pick_value(),
                 4'(($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(7)));
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Drain: all commands out and all results back, then a short tail
    while (cmd_q.size() != 0 || in_tvalid || resp_q.size() != 0)
      @(negedge clk);
    repeat (5) @(posedge clk);

    if (err_cnt == 0 && resp_q.size() == 0) begin
      $display("** sorted_list_table_unit: PASSED **");
    end else begin
      $display("** sorted_list_table_unit: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/slt_pkg.sv
rtl/slt_cell.sv
rtl/sorted_list_table_unit.sv
tb/tb_sorted_list_table_unit.sv
